// File: rtl/sew_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sew_pkg: shared types and constants for the spectral envelope warp
// Widths, register indexes, item kinds and status codes used by the frame
// memory and the warp sequencer.
// ----------------------------------------------------------------------------
package sew_pkg;

  localparam int unsigned MaxBins   = 1025;
  localparam int unsigned AddrW     = $clog2(MaxBins);
  localparam int unsigned IdxW      = 11;
  localparam int unsigned DataW     = 32;
  localparam int unsigned RateW     = 16;
  localparam int unsigned FracW     = 14;
  localparam int unsigned PosW      = IdxW + RateW;
  localparam int unsigned MulBW     = 16;
  localparam int unsigned ProdW     = DataW + MulBW;
  localparam int unsigned AccW      = DataW + FracW;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [FracW:0]  FracOne      = (FracW+1)'(1) << FracW;
  localparam logic [IdxW-1:0] MaxBinsIdx   = IdxW'(MaxBins);
  localparam logic [RateW-1:0] RateReset   = RateW'(16384);
  localparam logic [IdxW-1:0] CountReset   = IdxW'(513);

  // configuration register indexes
  localparam logic RegInvRate  = 1'b0;
  localparam logic RegBinCount = 1'b1;

  // item kinds
  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  // result status
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_POS  = 5'b00010,
    S_ADDR = 5'b00100,
    S_MULA = 5'b01000,
    S_MULB = 5'b10000
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } ram_req_t;

endpackage : sew_pkg
`default_nettype wire

// File: rtl/sew_frame_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sew_frame_ram: single-port frame store
// One access per cycle, either a write or a read; read data is registered.
// ----------------------------------------------------------------------------
module sew_frame_ram (
  input  wire logic                        clk_i,
  input  wire sew_pkg::ram_req_t           req_i,
  output logic      [sew_pkg::DataW-1:0]   rdata_o
);

  logic [sew_pkg::DataW-1:0] mem [sew_pkg::MaxBins];
  logic [sew_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end else begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule : sew_frame_ram
`default_nettype wire

// File: rtl/spectral_envelope_warp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_envelope_warp: formant shift of one spectral envelope frame
// Loads write bins into a frame store; a query resamples output bin i at
// source position i * inverse_rate (Q2.14) by linear interpolation.
//
//   channel   ports                                         transfer when
//   -------   --------------------------------------------  ---------------
//   item in   kind_i, bin_index_i, bin_value_i              start & !busy
//   result    warped_value_o, status_o                      done_o
//   config    cfg_idx_i, cfg_wdata_i                        cfg_we_i
//
// A load is stored at its transfer and gives no result; busy stays low. A
// query holds busy for the position multiply, two single-port frame memory
// reads and two multiply-accumulate steps on the one shared 32x16 multiplier;
// a clamp to the last bin ends it after the first step, an out-of-range index
// after the position multiply. done_o pulses in the first cycle busy is low.
// Results cannot be stalled; reset clears sequencer and configuration only.
// ----------------------------------------------------------------------------
module spectral_envelope_warp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // item channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             kind_i,
  input  wire logic [sew_pkg::IdxW-1:0]         bin_index_i,
  input  wire logic [sew_pkg::DataW-1:0]        bin_value_i,
  // result channel
  output logic                                  done_o,
  output logic      [sew_pkg::DataW-1:0]        warped_value_o,
  output logic                                  status_o,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [sew_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  sew_pkg::state_e state_q, state_d;

  logic [sew_pkg::RateW-1:0] rate_q;
  logic [sew_pkg::IdxW-1:0]  count_q;
  logic [sew_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [sew_pkg::PosW-1:0]  pos_q, pos_d;
  logic [sew_pkg::AccW-1:0]  acc_q, acc_d;
  logic                      clamp_q, clamp_d;
  logic                      done_q, done_d;
  logic [sew_pkg::DataW-1:0] warped_q, warped_d;
  logic                      status_q, status_d;

  logic [sew_pkg::IdxW-1:0]  n_eff;
  logic [sew_pkg::IdxW-1:0]  last_bin;
  logic [sew_pkg::PosW-1:0]  last_pos;
  logic [sew_pkg::FracW-1:0] frac;
  logic [sew_pkg::AddrW-1:0] lo_addr;
  logic                      out_of_range;
  logic                      accept;

  logic [sew_pkg::DataW-1:0] mul_a;
  logic [sew_pkg::MulBW-1:0] mul_b;
  logic [sew_pkg::ProdW-1:0] prod;
  logic [sew_pkg::AccW-1:0]  acc_sum;

  sew_pkg::ram_req_t         ram_req;
  logic [sew_pkg::DataW-1:0] ram_rdata;

  sew_frame_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != sew_pkg::S_IDLE);
  assign accept = start & ~busy;

  // bin count above the store depth saturates
  assign n_eff = (count_q > sew_pkg::MaxBinsIdx) ? sew_pkg::MaxBinsIdx : count_q;
  assign last_bin = n_eff - sew_pkg::IdxW'(1);
  assign last_pos = {(sew_pkg::PosW-sew_pkg::IdxW-sew_pkg::FracW)'(0), last_bin,
                     sew_pkg::FracW'(0)};
  assign out_of_range = (idx_q >= n_eff);
  assign frac    = pos_q[sew_pkg::FracW-1:0];
  assign lo_addr = pos_q[sew_pkg::FracW +: sew_pkg::AddrW];

  // shared multiplier
  always_comb begin
    mul_a = ram_rdata;
    mul_b = {(sew_pkg::MulBW-sew_pkg::FracW)'(0), frac};
    unique case (state_q)
      sew_pkg::S_POS: begin
        mul_a = {(sew_pkg::DataW-sew_pkg::IdxW)'(0), idx_q};
        mul_b = rate_q;
      end
      sew_pkg::S_MULA: begin
        mul_b = {(sew_pkg::MulBW-sew_pkg::FracW-1)'(0), sew_pkg::FracOne - {1'b0, frac}};
      end
      default: begin
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_sum = acc_q + prod[sew_pkg::AccW-1:0];

  // frame memory port
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.addr  = lo_addr;
    ram_req.wdata = bin_value_i;
    unique case (state_q)
      sew_pkg::S_IDLE: begin
        ram_req.addr = bin_index_i[sew_pkg::AddrW-1:0];
        ram_req.we   = accept && (kind_i == sew_pkg::KindLoad) &&
                       (bin_index_i < sew_pkg::MaxBinsIdx);
      end
      sew_pkg::S_ADDR: begin
        ram_req.addr = (pos_q >= last_pos) ? last_bin[sew_pkg::AddrW-1:0] : lo_addr;
      end
      sew_pkg::S_MULA: begin
        ram_req.addr = lo_addr + sew_pkg::AddrW'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    clamp_d  = clamp_q;
    done_d   = 1'b0;
    warped_d = warped_q;
    status_d = status_q;
    unique case (state_q)
      sew_pkg::S_IDLE: begin
        if (accept && (kind_i == sew_pkg::KindQuery)) begin
          idx_d   = bin_index_i;
          state_d = sew_pkg::S_POS;
        end
      end
      sew_pkg::S_POS: begin
        pos_d = prod[sew_pkg::PosW-1:0];
        if (out_of_range) begin
          done_d   = 1'b1;
          warped_d = '0;
          status_d = sew_pkg::StatusRange;
          state_d  = sew_pkg::S_IDLE;
        end else begin
          state_d = sew_pkg::S_ADDR;
        end
      end
      sew_pkg::S_ADDR: begin
        clamp_d = (pos_q >= last_pos);
        state_d = sew_pkg::S_MULA;
      end
      sew_pkg::S_MULA: begin
        acc_d = prod[sew_pkg::AccW-1:0];
        if (clamp_q) begin
          // position at or past the last bin: return it as is
          done_d   = 1'b1;
          warped_d = ram_rdata;
          status_d = sew_pkg::StatusOk;
          state_d  = sew_pkg::S_IDLE;
        end else begin
          state_d = sew_pkg::S_MULB;
        end
      end
      sew_pkg::S_MULB: begin
        done_d   = 1'b1;
        warped_d = acc_sum[sew_pkg::AccW-1:sew_pkg::FracW];
        status_d = sew_pkg::StatusOk;
        state_d  = sew_pkg::S_IDLE;
      end
      default: begin
        state_d = sew_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sew_pkg::S_IDLE;
      done_q  <= 1'b0;
      rate_q  <= sew_pkg::RateReset;
      count_q <= sew_pkg::CountReset;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sew_pkg::RegInvRate:  rate_q  <= cfg_wdata_i[sew_pkg::RateW-1:0];
          sew_pkg::RegBinCount: count_q <= cfg_wdata_i[sew_pkg::IdxW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    acc_q    <= acc_d;
    clamp_q  <= clamp_d;
    warped_q <= warped_d;
    status_q <= status_d;
  end

  assign done_o         = done_q;
  assign warped_value_o = warped_q;
  assign status_o       = status_q;

endmodule : spectral_envelope_warp
`default_nettype wire

// File: dv/spectral_envelope_warp_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_envelope_warp_chk: result checker for the spectral envelope warp
// Tracks register writes and frame loads, works out the warped value of
// every query accepted and compares it with the next result strobe.
// ----------------------------------------------------------------------------
module spectral_envelope_warp_chk import sew_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic                kind_i,
  input  logic [IdxW-1:0]     bin_index_i,
  input  logic [DataW-1:0]    bin_value_i,
  input  logic                done_o,
  input  logic [DataW-1:0]    warped_value_o,
  input  logic                status_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             status;
  } warp_result_t;

  warp_result_t     warp_results_q[$];
  logic [DataW-1:0] frame_bins [MaxBins];
  logic [RateW-1:0] inv_rate  = RateReset;
  logic [IdxW-1:0]  bin_count = CountReset;
  int               open_count  = 0;
  int               warp_errors = 0;

  assign pending_o = open_count;
  assign errors_o  = warp_errors;

  function automatic warp_result_t warp_bin(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] n;
    logic [IdxW-1:0] lo;
    logic [FracW-1:0] f;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] last;
    logic [AccW:0] acc;
    warp_result_t r;
    n = (bin_count > MaxBinsIdx) ? MaxBinsIdx : bin_count;
    r.status = StatusOk;
    if (idx >= n) begin
      r.value  = '0;
      r.status = StatusRange;
      return r;
    end
    pos  = PosW'(idx) * PosW'(inv_rate);
    last = PosW'(n - IdxW'(1)) << FracW;
    if (pos >= last) begin
      r.value = frame_bins[n - IdxW'(1)];
    end else begin
      lo  = pos[FracW +: IdxW];
      f   = pos[FracW-1:0];
      // weights sum to one, so the floored sum fits the data width
      acc = (AccW+1)'(frame_bins[lo]) * (AccW+1)'(FracOne - {1'b0, f}) +
            (AccW+1)'(frame_bins[lo + IdxW'(1)]) * (AccW+1)'(f);
      r.value = acc[FracW +: DataW];
    end
    return r;
  endfunction

  task automatic log_error(input string msg);
    warp_errors = warp_errors + 1;
    if (warp_errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    warp_result_t want;
    if (!rst_ni) begin
      warp_results_q.delete();
      open_count = 0;
      inv_rate   = RateReset;
      bin_count  = CountReset;
    end else begin
      // retire the oldest query before taking a new transfer
      if (done_o) begin
        if (warp_results_q.size() == 0) begin
          log_error($sformatf("%0t: result with no query open: value %h status %0d",
                              $time, warped_value_o, status_o));
        end else begin
          want = warp_results_q.pop_front();
          if (warped_value_o !== want.value || status_o !== want.status) begin
            log_error($sformatf({"%0t: warp mismatch: expected value %h status %0d,",
                                 " got value %h status %0d"},
                                $time, want.value, want.status, warped_value_o,
                                status_o));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == RegInvRate) inv_rate = cfg_wdata_i[RateW-1:0];
        else bin_count = cfg_wdata_i[IdxW-1:0];
      end
      if (start && !busy) begin
        if (kind_i == KindLoad) begin
          if (bin_index_i < MaxBinsIdx) frame_bins[bin_index_i] = bin_value_i;
        end else begin
          warp_results_q.push_back(warp_bin(bin_index_i));
        end
      end
      open_count = warp_results_q.size();
    end
  end

endmodule

// File: dv/spectral_envelope_warp_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_envelope_warp_tb: testbench top for the spectral envelope warp
// Loads frames and issues warped-bin queries under several rate and bin
// count settings and idle patterns; the checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module spectral_envelope_warp_tb;
  import sew_pkg::*;

  localparam int ItemTarget = 1150;
  localparam int CycleLimit = 500000;
  localparam int SettleCycles = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                kind_i = KindLoad;
  logic [IdxW-1:0]     bin_index_i = '0;
  logic [DataW-1:0]    bin_value_i = '0;
  logic                done_o;
  logic [DataW-1:0]    warped_value_o;
  logic                status_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = RegInvRate;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  int open_queries;
  int warp_errors;
  int cycle_count = 0;
  int items_sent = 0;
  int idle_pct [4] = '{0, 87, 0, 30};

  // stimulus-side copy of the settings and of which bins hold data
  logic [RateW-1:0] rate_cfg = RateReset;
  logic [IdxW-1:0]  count_cfg = CountReset;
  bit               loaded_bins [MaxBins];

  spectral_envelope_warp dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .bin_index_i    (bin_index_i),
    .bin_value_i    (bin_value_i),
    .done_o         (done_o),
    .warped_value_o (warped_value_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  spectral_envelope_warp_chk warp_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .bin_index_i    (bin_index_i),
    .bin_value_i    (bin_value_i),
    .done_o         (done_o),
    .warped_value_o (warped_value_o),
    .status_o       (status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pending_o      (open_queries),
    .errors_o       (warp_errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("spectral_envelope_warp_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IdxW-1:0] active_bins();
    return (count_cfg > MaxBinsIdx) ? MaxBinsIdx : count_cfg;
  endfunction

  // Present one item and hold it until the transfer; start stays high.
  task automatic send_item(input logic kind, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] val);
    bit taken;
    start       <= 1'b1;
    kind_i      <= kind;
    bin_index_i <= idx;
    bin_value_i <= val;
    do begin
      taken = !busy;
      @(negedge clk_i);
    end while (!taken);
    if (kind == KindLoad && idx < MaxBinsIdx) loaded_bins[idx] = 1'b1;
    if (!(kind == KindLoad && idx >= MaxBinsIdx)) items_sent++;
  endtask

  // Load any source bin the query reads that holds no data, then send the query.
  task automatic query_bin(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] n;
    logic [IdxW-1:0] lo;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] last;
    n = active_bins();
    if (idx < n) begin
      pos  = PosW'(idx) * PosW'(rate_cfg);
      last = PosW'(n - IdxW'(1)) << FracW;
      if (pos >= last) begin
        if (!loaded_bins[n - IdxW'(1)]) send_item(KindLoad, n - IdxW'(1), rand_value());
      end else begin
        lo = pos[FracW +: IdxW];
        if (!loaded_bins[lo]) send_item(KindLoad, lo, rand_value());
        if (!loaded_bins[lo + IdxW'(1)]) send_item(KindLoad, lo + IdxW'(1), rand_value());
      end
    end
    send_item(KindQuery, idx, $urandom);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Hold off until every query has answered and the block has settled.
  task automatic drain();
    start <= 1'b0;
    while (open_queries != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [RateW-1:0] rate,
                            input logic [CfgDataW-1:0] count_word);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegInvRate;
    cfg_wdata_i <= rate;
    @(negedge clk_i);
    cfg_idx_i   <= RegBinCount;
    cfg_wdata_i <= count_word;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    rate_cfg  = rate;
    count_cfg = count_word[IdxW-1:0];
  endtask

  initial begin
    int phase;
    int phase_len;
    int pct;
    bit sweep;
    logic [RateW-1:0] rate;
    logic [IdxW-1:0] cnt;
    logic [4:0] pad;
    logic [IdxW-1:0] n;
    logic [IdxW-1:0] idx;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: value extremes, no shift, range edges, ignored loads
    send_item(KindLoad, 11'd0, '0);
    send_item(KindLoad, 11'd1, '1);
    send_item(KindLoad, 11'd2, 32'h8000_0001);
    query_bin(11'd0);
    query_bin(11'd1);
    query_bin(11'd2);
    send_item(KindLoad, 11'd1024, $urandom);
    send_item(KindLoad, 11'd1025, $urandom);
    send_item(KindLoad, 11'd2047, '1);
    query_bin(11'd513);
    query_bin(11'd2047);
    // half rate lands midway between bins
    set_config(16'd8192, 16'd513);
    query_bin(11'd1);
    query_bin(11'd3);
    set_config(16'hFFFF, 16'd1025);
    query_bin(11'd1);
    query_bin(11'd1024);
    // zero rate always reads the first bin
    set_config(16'd0, 16'd513);
    query_bin(11'd500);
    set_config(16'd16384, 16'd0);
    query_bin(11'd0);
    set_config(16'd16384, 16'd1);
    query_bin(11'd0);
    query_bin(11'd1);
    // oversized bin count clamps to the store depth
    set_config(16'd32768, 16'hFFFF);
    query_bin(11'd600);
    query_bin(11'd1024);

    phase = 0;
    while (items_sent < ItemTarget) begin
      case ($urandom_range(6))
        0:       rate = '0;
        1:       rate = '1;
        2:       rate = 16'd8192;
        3:       rate = 16'd32768;
        4:       rate = 16'd16384;
        5:       rate = RateW'($urandom);
        default: rate = RateW'($urandom_range(32768, 8192));
      endcase
      case ($urandom_range(7))
        0:       cnt = 11'd0;
        1:       cnt = 11'd1;
        2:       cnt = 11'd2;
        3:       cnt = 11'd1025;
        4:       cnt = IdxW'($urandom_range(2047, 1026));
        5:       cnt = IdxW'($urandom_range(1025, 2));
        default: cnt = IdxW'($urandom_range(40, 2));
      endcase
      pad = 5'($urandom);
      set_config(rate, {pad, cnt});
      n         = active_bins();
      pct       = idle_pct[phase % 4];
      sweep     = phase[0];
      phase_len = $urandom_range(200, 60);

      // refresh the head of the frame with new content
      if ($urandom_range(1) == 0) begin
        for (int b = 0; b < n && b < 48; b++) begin
          idle_gap(pct);
          send_item(KindLoad, IdxW'(b), rand_value());
        end
      end

      for (int k = 0; k < phase_len && items_sent < ItemTarget; k++) begin
        idle_gap(pct);
        if ($urandom_range(99) < 35) begin
          idx = ($urandom_range(9) == 0) ? IdxW'($urandom_range(2047))
                                         : IdxW'($urandom_range(n + 3));
          send_item(KindLoad, idx, rand_value());
        end else begin
          if (sweep) idx = IdxW'(k % (int'(n) + 1));
          else if ($urandom_range(9) == 0) idx = IdxW'($urandom_range(2047));
          else idx = IdxW'($urandom_range(n + 2));
          query_bin(idx);
        end
        if ($urandom_range(99) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (warp_errors == 0) begin
      $display("spectral_envelope_warp_tb: done, clean");
    end else begin
      $display("spectral_envelope_warp_tb: done, errors");
    end
    $finish;
  end

endmodule
